// ===== src/hlt_pkg.sv =====
package hlt_pkg;

  // Walk runs this many steps past the end hex
  localparam int OVERSHOOT = 3;
  // Most hexes one trajectory may hold
  localparam int MAX_OUT   = 64;
  localparam int AW        = $clog2(MAX_OUT);
  localparam int CNT_W     = AW + 1;

  // Field widths
  localparam int IN_W    = 5;
  localparam int OUT_W   = 8;
  localparam int CUBE_W  = 7;   // cube coordinate of an input hex
  localparam int DIFF_W  = 8;   // difference of two cube coordinates
  localparam int D_W     = 6;   // hex distance, at most 62
  localparam int NUM_W   = 15;  // interpolation numerator, signed
  localparam int ROUND_W = 9;   // rounded coordinate, signed
  localparam int ERR_W   = 7;   // doubled rounding error numerator

  // Shared divider widths
  localparam int DVD_W   = 15;
  localparam int DSR_W   = 7;
  localparam int DCNT_W  = $clog2(DVD_W);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== src/hlt_divider.sv =====
// Restoring divider, one quotient bit per cycle
module hlt_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hlt_pkg::div_req_t req_i,
  output hlt_pkg::div_rsp_t rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [hlt_pkg::DCNT_W-1:0]       cnt_q;
  logic [hlt_pkg::DSR_W-1:0]        rem_q;
  logic [hlt_pkg::DSR_W-1:0]        dsr_q;
  logic [hlt_pkg::DVD_W-1:0]        quo_q;
  logic [hlt_pkg::DSR_W:0]          trial;
  logic                             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[hlt_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= hlt_pkg::DSR_W'(trial - {1'b0, dsr_q});
        end else begin
          rem_q <= trial[hlt_pkg::DSR_W-1:0];
        end
        quo_q <= {quo_q[hlt_pkg::DVD_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == hlt_pkg::DCNT_W'(hlt_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== src/hex_line_trajectory.sv =====
// Hex line trajectory on an axial hex grid.
// Input channel (in_valid_i / in_stall_o) takes one transaction: a start and an
// end hex in axial (q, r). The output channel (out_valid_o / out_stall_i) then
// gives every distinct hex of the line walk, at most 64, start first, running
// three steps past the end hex; last_hex_o marks the final hex of the trajectory.
// Equal start and end give the start hex alone.
// Each walk step takes three rounded divisions through one serial divider and a
// duplicate scan over the hexes already produced, which reads a 64-entry hex
// store one entry at a time.
// One transaction is worked on at a time: in_stall_o stays high from accept
// until the last hex has been loaded into the output register.
// The output register holds a hex while out_stall_i is high; the walk waits
// for it before loading the next one, so nothing is dropped.
// Reset (rst_ni low, asynchronous) returns to idle and empties the output.
module hex_line_trajectory (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [4:0]          start_q_i,
  input  logic signed [4:0]          start_r_i,
  input  logic signed [4:0]          end_q_i,
  input  logic signed [4:0]          end_r_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [7:0]          hex_q_o,
  output logic signed [7:0]          hex_r_o,
  output logic                       last_hex_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PICK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_NEW,
    ST_NEXT,
    ST_FINISH
  } state_e;

  localparam int HEX_W = 2 * hlt_pkg::OUT_W;

  state_e state_q;

  // Latched endpoints
  logic signed [hlt_pkg::IN_W-1:0]    q1_q, r1_q, q2_q, r2_q;

  // Walk state
  logic [hlt_pkg::D_W-1:0]            d_q;
  logic signed [hlt_pkg::NUM_W-1:0]   num_q [3];
  logic signed [hlt_pkg::DIFF_W-1:0]  dc_q [3];
  logic signed [hlt_pkg::ROUND_W-1:0] val_q [3];
  logic [hlt_pkg::ERR_W-1:0]          err_q [3];
  logic [1:0]                         k_q;
  logic [hlt_pkg::CNT_W:0]            i_q;
  logic [hlt_pkg::CNT_W-1:0]          n_q;
  logic [hlt_pkg::CNT_W-1:0]          idx_q;
  logic [HEX_W-1:0]                   cand_q;
  logic [HEX_W-1:0]                   pend_q;
  logic                               have_pend_q;

  // Output register
  logic                               out_valid_q;
  logic [hlt_pkg::OUT_W-1:0]          out_q_q, out_r_q;
  logic                               out_last_q;

  // Hex store
  logic [HEX_W-1:0]                   seen_mem [hlt_pkg::MAX_OUT];
  logic [HEX_W-1:0]                   rd_q;
  logic                               mem_we;

  hlt_pkg::div_req_t                  div_req;
  hlt_pkg::div_rsp_t                  div_rsp;

  // Setup arithmetic on the latched endpoints
  logic signed [hlt_pkg::CUBE_W-1:0]  q1_c, r1_c, s1_c, q2_c, r2_c, s2_c;
  logic signed [hlt_pkg::DIFF_W-1:0]  dq, dr, ds;
  logic [hlt_pkg::DIFF_W-1:0]         adq, adr, ads, dsum;
  logic [hlt_pkg::D_W-1:0]            d_calc;
  logic signed [hlt_pkg::D_W:0]       d_sgn;
  logic signed [hlt_pkg::NUM_W-1:0]   init_q, init_r, init_s;

  // Division operands and results
  logic signed [hlt_pkg::NUM_W-1:0]   num_k;
  logic [hlt_pkg::NUM_W-1:0]          num_abs;
  logic signed [hlt_pkg::ROUND_W-1:0] mag;
  logic signed [hlt_pkg::DIFF_W-1:0]  err_diff;
  logic [hlt_pkg::DIFF_W-1:0]         err_abs;

  // Hex pick
  logic signed [hlt_pkg::ROUND_W-1:0] fq, fr;

  // Step control
  logic [hlt_pkg::CNT_W:0]            i_limit;
  logic                               can_load;

  assign q1_c = hlt_pkg::CUBE_W'(q1_q);
  assign r1_c = hlt_pkg::CUBE_W'(r1_q);
  assign q2_c = hlt_pkg::CUBE_W'(q2_q);
  assign r2_c = hlt_pkg::CUBE_W'(r2_q);
  assign s1_c = -q1_c - r1_c;
  assign s2_c = -q2_c - r2_c;

  assign dq = hlt_pkg::DIFF_W'(q2_c) - hlt_pkg::DIFF_W'(q1_c);
  assign dr = hlt_pkg::DIFF_W'(r2_c) - hlt_pkg::DIFF_W'(r1_c);
  assign ds = hlt_pkg::DIFF_W'(s2_c) - hlt_pkg::DIFF_W'(s1_c);

  assign adq    = dq[hlt_pkg::DIFF_W-1] ? hlt_pkg::DIFF_W'(-dq) : hlt_pkg::DIFF_W'(dq);
  assign adr    = dr[hlt_pkg::DIFF_W-1] ? hlt_pkg::DIFF_W'(-dr) : hlt_pkg::DIFF_W'(dr);
  assign ads    = ds[hlt_pkg::DIFF_W-1] ? hlt_pkg::DIFF_W'(-ds) : hlt_pkg::DIFF_W'(ds);
  assign dsum   = adq + adr + ads;
  assign d_calc = dsum[hlt_pkg::D_W:1];
  assign d_sgn  = $signed({1'b0, d_calc});

  // Start numerators c1 * d
  assign init_q = hlt_pkg::NUM_W'(q1_c * d_sgn);
  assign init_r = hlt_pkg::NUM_W'(r1_c * d_sgn);
  assign init_s = hlt_pkg::NUM_W'(s1_c * d_sgn);

  // Round half away from zero: mag = (2|num| + d) / (2d)
  assign num_k   = num_q[k_q];
  assign num_abs = num_k[hlt_pkg::NUM_W-1] ? hlt_pkg::NUM_W'(-num_k)
                                           : hlt_pkg::NUM_W'(num_k);
  assign div_req.start    = (state_q == ST_DIV_GO);
  assign div_req.dividend = hlt_pkg::DVD_W'({num_abs, 1'b0}) + hlt_pkg::DVD_W'(d_q);
  assign div_req.divisor  = hlt_pkg::DSR_W'({d_q, 1'b0});

  hlt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Rounded value and doubled error |d - rem|
  assign mag = $signed({1'b0, div_rsp.quotient[hlt_pkg::OUT_W-1:0]});
  assign err_diff = $signed(hlt_pkg::DIFF_W'(d_q))
                  - $signed(hlt_pkg::DIFF_W'(div_rsp.remainder));
  assign err_abs  = err_diff[hlt_pkg::DIFF_W-1] ? hlt_pkg::DIFF_W'(-err_diff)
                                                : hlt_pkg::DIFF_W'(err_diff);

  // Rebuild the coordinate with the largest error; ties favor q, then r
  always_comb begin
    if (err_q[0] >= err_q[1] && err_q[0] >= err_q[2]) begin
      fq = -val_q[1] - val_q[2];
      fr = val_q[1];
    end else if (err_q[1] >= err_q[2]) begin
      fq = val_q[0];
      fr = -val_q[0] - val_q[2];
    end else begin
      fq = val_q[0];
      fr = val_q[1];
    end
  end

  assign i_limit    = (hlt_pkg::CNT_W + 1)'(d_q) + (hlt_pkg::CNT_W + 1)'(hlt_pkg::OVERSHOOT);
  assign can_load   = !out_valid_q || !out_stall_i;
  assign mem_we     = (state_q == ST_NEW) && (!have_pend_q || can_load);
  assign in_stall_o = (state_q != ST_IDLE);

  // Hex store: written at the fill count, read during the scan
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seen_mem[n_q[hlt_pkg::AW-1:0]] <= cand_q;
    end
    rd_q <= seen_mem[idx_q[hlt_pkg::AW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q1_q        <= '0;
      r1_q        <= '0;
      q2_q        <= '0;
      r2_q        <= '0;
      d_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      cand_q      <= '0;
      pend_q      <= '0;
      have_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q_q     <= '0;
      out_r_q     <= '0;
      out_last_q  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        num_q[c] <= '0;
        dc_q[c]  <= '0;
        val_q[c] <= '0;
        err_q[c] <= '0;
      end
    end else begin
      // Output register drains on transaction
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            q1_q    <= start_q_i;
            r1_q    <= start_r_i;
            q2_q    <= end_q_i;
            r2_q    <= end_r_i;
            state_q <= ST_SETUP;
          end
        end

        ST_SETUP: begin
          d_q         <= d_calc;
          num_q[0]    <= init_q;
          num_q[1]    <= init_r;
          num_q[2]    <= init_s;
          dc_q[0]     <= dq;
          dc_q[1]     <= dr;
          dc_q[2]     <= ds;
          i_q         <= '0;
          n_q         <= '0;
          k_q         <= '0;
          have_pend_q <= 1'b0;
          if (d_calc == '0) begin
            pend_q      <= {hlt_pkg::OUT_W'(q1_q), hlt_pkg::OUT_W'(r1_q)};
            have_pend_q <= 1'b1;
            state_q     <= ST_FINISH;
          end else begin
            state_q <= ST_DIV_GO;
          end
        end

        ST_DIV_GO: begin
          state_q <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            val_q[k_q] <= num_k[hlt_pkg::NUM_W-1] ? -mag : mag;
            err_q[k_q] <= err_abs[hlt_pkg::ERR_W-1:0];
            if (k_q == 2'd2) begin
              state_q <= ST_PICK;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_DIV_GO;
            end
          end
        end

        ST_PICK: begin
          cand_q  <= {fq[hlt_pkg::OUT_W-1:0], fr[hlt_pkg::OUT_W-1:0]};
          idx_q   <= '0;
          state_q <= ST_SCAN_RD;
        end

        ST_SCAN_RD: begin
          if (idx_q == n_q) begin
            state_q <= ST_NEW;
          end else begin
            state_q <= ST_SCAN_CMP;
          end
        end

        ST_SCAN_CMP: begin
          if (rd_q == cand_q) begin
            state_q <= ST_NEXT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_SCAN_RD;
          end
        end

        ST_NEW: begin
          if (mem_we) begin
            // Previous hex is now known not to be the last
            if (have_pend_q) begin
              out_valid_q <= 1'b1;
              out_q_q     <= pend_q[HEX_W-1:hlt_pkg::OUT_W];
              out_r_q     <= pend_q[hlt_pkg::OUT_W-1:0];
              out_last_q  <= 1'b0;
            end
            pend_q      <= cand_q;
            have_pend_q <= 1'b1;
            n_q         <= n_q + 1'b1;
            if (n_q == hlt_pkg::CNT_W'(hlt_pkg::MAX_OUT - 1)) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end

        ST_NEXT: begin
          for (int c = 0; c < 3; c++) begin
            num_q[c] <= num_q[c] + hlt_pkg::NUM_W'(dc_q[c]);
          end
          i_q <= i_q + 1'b1;
          k_q <= '0;
          if (i_q >= i_limit) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV_GO;
          end
        end

        ST_FINISH: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            out_q_q     <= pend_q[HEX_W-1:hlt_pkg::OUT_W];
            out_r_q     <= pend_q[hlt_pkg::OUT_W-1:0];
            out_last_q  <= 1'b1;
            have_pend_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hex_q_o     = $signed(out_q_q);
  assign hex_r_o     = $signed(out_r_q);
  assign last_hex_o  = out_last_q;

endmodule
